@@ src/lfp_pkg.sv @@
// Shared widths and constants for the line-from-two-points pipeline.
`timescale 1ns / 1ps

package lfp_pkg;

  localparam int CoordW  = 32;               // Q16.16 point coordinate
  localparam int DiffW   = 33;               // b - a without overflow
  localparam int SqW     = 64;               // |d|^2
  localparam int SumW    = 66;               // S = sum of three squares
  localparam int RemW    = 124;              // d^2 * 2^60
  localparam int AccW    = 97;               // q * S
  localparam int WideW   = 130;              // trial subtrahend
  localparam int QBits   = 31;               // magnitude bits of the unit component
  localparam int ProdW   = 64;               // coordinate times unit component
  localparam int MomW    = 33;               // Q16.16 moment component
  localparam int InDataW  = 192;
  localparam int OutDataW = 200;

endpackage

@@ src/line_from_two_points_core.sv @@
// Pipelined Plucker line builder: unit direction and moment from two points.
// A pair passes the difference, square, seed, square-root, product and output stages.
// Throughput: one pair per cycle unless stalled; a square-root bit per stage, 31 stages.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module line_from_two_points_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // ax, ay, az, bx, by, bz (32 bits each)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata    // line_valid, dir_x/y/z (32), mom_x/y/z (33), 4'b0
);

  localparam int NStage = 3 + lfp_pkg::QBits + 2;
  localparam int DiffW = lfp_pkg::DiffW;

  logic en;
  logic [NStage-1:0] vld_q;

  assign en            = m_axis_tready || !vld_q[NStage-1];
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NStage-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStage-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: coordinates and difference.
  logic signed [lfp_pkg::CoordW-1:0] a1_q [3];
  logic signed [lfp_pkg::DiffW-1:0]  d1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i] <= signed'(s_axis_tdata[i*32 +: 32]);
        d1_q[i] <= DiffW'(signed'(s_axis_tdata[(i+3)*32 +: 32]))
                 - DiffW'(signed'(s_axis_tdata[i*32 +: 32]));
      end
    end
  end

  // Stage 2: squares and signs.
  logic signed [lfp_pkg::CoordW-1:0] a2_q [3];
  logic [lfp_pkg::SqW-1:0]           sq2_q [3];
  logic                              neg2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [lfp_pkg::DiffW-1:0] mag;
        mag = d1_q[i][DiffW-1] ? DiffW'(-d1_q[i]) : DiffW'(d1_q[i]);
        a2_q[i]   <= a1_q[i];
        neg2_q[i] <= d1_q[i][DiffW-1];
        sq2_q[i]  <= mag[31:0] * mag[31:0];
      end
    end
  end

  // Square-root pipeline state; index 0 is the seed stage.
  logic [lfp_pkg::RemW-1:0]          r_q   [lfp_pkg::QBits+1][3];
  logic [lfp_pkg::AccW-1:0]          y_q   [lfp_pkg::QBits+1][3];
  logic [lfp_pkg::QBits-1:0]         q_q   [lfp_pkg::QBits+1][3];
  logic                              neg_q [lfp_pkg::QBits+1][3];
  logic signed [lfp_pkg::CoordW-1:0] a_q   [lfp_pkg::QBits+1][3];
  logic [lfp_pkg::SumW-1:0]          s_q   [lfp_pkg::QBits+1];
  logic                              nz_q  [lfp_pkg::QBits+1];

  // Stage 3: squared length and remainders seeded with d^2 * 2^60.
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [lfp_pkg::SumW-1:0] sum;
      sum = lfp_pkg::SumW'(sq2_q[0]) + lfp_pkg::SumW'(sq2_q[1]) + lfp_pkg::SumW'(sq2_q[2]);
      s_q[0]  <= sum;
      nz_q[0] <= (sum != '0);
      for (int i = 0; i < 3; i++) begin
        r_q[0][i]   <= {sq2_q[i], 60'b0};
        y_q[0][i]   <= '0;
        q_q[0][i]   <= '0;
        neg_q[0][i] <= neg2_q[i];
        a_q[0][i]   <= a2_q[i];
      end
    end
  end

  // Each stage tries one bit of q: keep it when (q+2^b)^2*S still fits under d^2*2^60.
  // R holds d^2*2^60 - q^2*S and Y holds q*S, so the trial is a shift-add and a compare.
  for (genvar k = 0; k < lfp_pkg::QBits; k++) begin : g_bit
    localparam int B = lfp_pkg::QBits - 1 - k;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [lfp_pkg::WideW-1:0] sub;
      logic                      take;
      assign sub  = (lfp_pkg::WideW'(y_q[k][l]) << (B + 1))
                  + (lfp_pkg::WideW'(s_q[k]) << (2 * B));
      assign take = sub <= lfp_pkg::WideW'(r_q[k][l]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          r_q[k+1][l]   <= take ? r_q[k][l] - sub[lfp_pkg::RemW-1:0] : r_q[k][l];
          y_q[k+1][l]   <= take ? y_q[k][l] + (lfp_pkg::AccW'(s_q[k]) << B) : y_q[k][l];
          q_q[k+1][l]   <= q_q[k][l] | (lfp_pkg::QBits'(take) << B);
          neg_q[k+1][l] <= neg_q[k][l];
          a_q[k+1][l]   <= a_q[k][l];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_q[k+1]  <= s_q[k];
        nz_q[k+1] <= nz_q[k];
      end
    end
  end

  // Product stage: signed unit direction and the six cross-product terms.
  localparam int QL = lfp_pkg::QBits;
  logic signed [lfp_pkg::CoordW-1:0] u;
  logic signed [lfp_pkg::CoordW-1:0] uv [3];
  logic signed [lfp_pkg::CoordW-1:0] u_q [3];
  logic signed [lfp_pkg::ProdW-1:0]  p_q [6];
  logic                              nzp_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u     = signed'({1'b0, q_q[QL][i]});
      uv[i] = neg_q[QL][i] ? -u : u;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q   <= uv;
      nzp_q <= nz_q[QL];
      p_q[0] <= a_q[QL][1] * uv[2];
      p_q[1] <= a_q[QL][2] * uv[1];
      p_q[2] <= a_q[QL][2] * uv[0];
      p_q[3] <= a_q[QL][0] * uv[2];
      p_q[4] <= a_q[QL][0] * uv[1];
      p_q[5] <= a_q[QL][1] * uv[0];
    end
  end

  // Output stage: difference, round half up to Q16.16, zero when degenerate.
  logic signed [65:0]                diff [3];
  logic signed [lfp_pkg::MomW-1:0]   mom  [3];
  logic [lfp_pkg::OutDataW-1:0]      out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = 66'(p_q[2*i]) - 66'(p_q[2*i+1]) + 66'(signed'(66'd536870912));
      mom[i]  = diff[i][62:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (nzp_q) begin
        out_q <= {4'b0, mom[2], mom[1], mom[0], u_q[2], u_q[1], u_q[0], 1'b1};
      end else begin
        out_q <= '0;
      end
    end
  end

  assign m_axis_tdata = out_q;

endmodule

@@ bench/testbench.sv @@
// Self-checking stream testbench for the Plucker line builder.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic        ok;
    logic [31:0] dir_x, dir_y, dir_z;
    logic [32:0] mom_x, mom_y, mom_z;
  } line_t;

  typedef struct {
    logic [191:0] pts;
    bit           has_lit;
    line_t        lit;
  } stim_row_t;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;
  localparam logic [31:0] One30 = 32'h4000_0000;

  logic clk, rst_n;
  logic s_tvalid, s_tready, m_tvalid;
  logic m_tready = 1'b0;
  logic [lfp_pkg::InDataW-1:0] s_tdata;   // ax, ay, az, bx, by, bz (32 bits each)
  logic [lfp_pkg::OutDataW-1:0] m_tdata;  // line_valid, dir_x/y/z, mom_x/y/z, zero pad

  line_t expected_lines[$];
  int errors = 0;
  int cycles = 0;
  bit tx_calm = 0, rx_calm = 0;

  line_from_two_points_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Unit direction by a bitwise square-root search, moment rounded half up.
  function automatic line_t plucker_line(input logic [191:0] pts);
    longint a[3], d[3], u[3], p[3];
    logic [63:0] ad;
    logic [65:0] len2;
    logic [131:0] lhs, rhs;
    logic [63:0] q, t;
    line_t r;
    r = '0;
    len2 = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(pts[32*i +: 32]));
      d[i] = longint'($signed(pts[32*(i+3) +: 32])) - a[i];
      ad = (d[i] < 0) ? -d[i] : d[i];
      len2 = len2 + ad * ad;
    end
    if (len2 == 0) return r;
    for (int i = 0; i < 3; i++) begin
      ad = (d[i] < 0) ? -d[i] : d[i];
      rhs = ad;
      rhs = (rhs * rhs) << 60;
      q = 0;
      for (int b = 30; b >= 0; b--) begin
        t = q | (64'd1 << b);
        lhs = t;
        lhs = lhs * lhs * len2;
        if (lhs <= rhs) q = t;
      end
      u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
    end
    p[0] = a[1] * u[2] - a[2] * u[1];
    p[1] = a[2] * u[0] - a[0] * u[2];
    p[2] = a[0] * u[1] - a[1] * u[0];
    for (int i = 0; i < 3; i++) p[i] = (p[i] + (64'sd1 <<< 29)) >>> 30;
    r.ok = 1'b1;
    r.dir_x = u[0][31:0];
    r.dir_y = u[1][31:0];
    r.dir_z = u[2][31:0];
    r.mom_x = p[0][32:0];
    r.mom_y = p[1][32:0];
    r.mom_z = p[2][32:0];
    return r;
  endfunction

  function automatic logic [191:0] pack_pts(input logic [31:0] ax, ay, az, bx, by, bz);
    return {bz, by, bx, az, ay, ax};
  endfunction

  task automatic send_pair(input logic [191:0] pts, input bit has_lit, input line_t lit);
    int g;
    g = tx_calm ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pts;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_lines.push_back(has_lit ? lit : plucker_line(pts));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  // Result checking: every transfer on the master side against the oldest expectation.
  always @(posedge clk) begin
    line_t got, want;
    if (rst_n && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[32:1], m_tdata[64:33], m_tdata[96:65],
             m_tdata[129:97], m_tdata[162:130], m_tdata[195:163]};
      if (expected_lines.size() == 0) begin
        $display("%t: unexpected result %h", $realtime, m_tdata);
        errors++;
      end else begin
        want = expected_lines.pop_front();
        if (got.ok !== want.ok) begin
          $display("%t: line_valid exp %0d got %0d", $realtime, want.ok, got.ok); errors++;
        end
        if (got.dir_x !== want.dir_x) begin
          $display("%t: dir_x exp %h got %h", $realtime, want.dir_x, got.dir_x); errors++;
        end
        if (got.dir_y !== want.dir_y) begin
          $display("%t: dir_y exp %h got %h", $realtime, want.dir_y, got.dir_y); errors++;
        end
        if (got.dir_z !== want.dir_z) begin
          $display("%t: dir_z exp %h got %h", $realtime, want.dir_z, got.dir_z); errors++;
        end
        if (got.mom_x !== want.mom_x) begin
          $display("%t: mom_x exp %h got %h", $realtime, want.mom_x, got.mom_x); errors++;
        end
        if (got.mom_y !== want.mom_y) begin
          $display("%t: mom_y exp %h got %h", $realtime, want.mom_y, got.mom_y); errors++;
        end
        if (got.mom_z !== want.mom_z) begin
          $display("%t: mom_z exp %h got %h", $realtime, want.mom_z, got.mom_z); errors++;
        end
      end
    end
  end

  // Receiver backpressure, with calm stretches where it never stalls.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) rx_calm <= ~rx_calm;
    if (rx_calm) m_tready <= 1'b1;
    else if (r < 5) m_tready <= 1'b0;
    else if (r < 40) m_tready <= ~m_tready;
    else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    line_t lit;
    logic [31:0] c[6];
    int kind;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    rst_n    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coincident points give an all-zero result.
    row = '{pts: '0, has_lit: 1, lit: '0}; rows.push_back(row);
    row.pts = {6{32'h7fff_ffff}}; rows.push_back(row);
    row.pts = {6{32'h8000_0000}}; rows.push_back(row);
    row.pts = {6{32'hffff_ffff}}; rows.push_back(row);
    // Axis-aligned lines give an exact unit component.
    lit = '0; lit.ok = 1; lit.dir_x = One30;
    row = '{pts: pack_pts(0, 0, 0, 1, 0, 0), has_lit: 1, lit: lit}; rows.push_back(row);
    lit = '0; lit.ok = 1; lit.dir_y = -One30;
    row = '{pts: pack_pts(0, 0, 0, 0, -5, 0), has_lit: 1, lit: lit}; rows.push_back(row);
    lit = '0; lit.ok = 1; lit.dir_z = One30; lit.mom_y = -33'sd65536;
    row = '{pts: pack_pts(65536, 0, 0, 65536, 0, 65536), has_lit: 1, lit: lit};
    rows.push_back(row);
    // Extremes of the coordinate range and small offsets, checked by prediction.
    row.has_lit = 0;
    row.pts = pack_pts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff); rows.push_back(row);
    row.pts = pack_pts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000); rows.push_back(row);
    row.pts = pack_pts(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000); rows.push_back(row);
    row.pts = pack_pts(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff, 1);
    rows.push_back(row);
    row.pts = pack_pts(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000); rows.push_back(row);
    row.pts = pack_pts(1, 2, 3, 4, 6, 8); rows.push_back(row);
    row.pts = pack_pts(-65536, 131072, 3, 65536, -65536, 7); rows.push_back(row);
    row.pts = pack_pts(0, 0, 0, 1, 1, 1); rows.push_back(row);
    row.pts = pack_pts(0, 0, 0, -1, 1, -1); rows.push_back(row);

    tx_calm = 1;
    foreach (rows[i]) send_pair(rows[i].pts, rows[i].has_lit, rows[i].lit);
    tx_calm = 0;

    for (int n = 0; n < 1500; n++) begin
      if (n == 700) wait_drained();
      if (n % 97 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
        c[i] = $urandom;
        if (kind < 3) c[i] = $signed(c[i]) >>> $urandom_range(0, 30);
      end
      if (kind == 3) begin
        c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
      end else if (kind == 4) begin
        // Displacement along one axis only.
        c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
        c[3 + $urandom_range(0, 2)] = $urandom;
      end else if (kind == 5) begin
        c[3] = c[0] + $urandom_range(0, 3) - 1;
        c[4] = c[1] + $urandom_range(0, 3) - 1;
        c[5] = c[2] + $urandom_range(0, 3) - 1;
      end
      send_pair(pack_pts(c[0], c[1], c[2], c[3], c[4], c[5]), 0, '0);
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ line_from_two_points_core.f @@
src/lfp_pkg.sv
src/line_from_two_points_core.sv
bench/testbench.sv
